[design/ip_header_fragment_parser_macros.svh]
// ----------------------------------------------------------------------------
// IP header fragment parser assertion macros
// Shorthand for clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef IP_HEADER_FRAGMENT_PARSER_MACROS_SVH
`define IP_HEADER_FRAGMENT_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IHFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ihfp_pkg.sv]
// ----------------------------------------------------------------------------
// ihfp_pkg
// Shared types and constants of the IP header fragment parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihfp_pkg;

  // Largest header the parser walks before reporting too long.
  localparam int MAX_HEADER_BYTES = 4096;
  localparam int POS_BITS_NEEDED  = $clog2(MAX_HEADER_BYTES + 1);
  // Position width; never below the 13-bit header_length field.
  localparam int POS_W = (POS_BITS_NEEDED > 13) ? POS_BITS_NEEDED : 13;

  // Result status codes
  localparam logic [1:0] STATUS_COMPLETE    = 2'd0;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED   = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG    = 2'd3;

  // IP versions
  localparam logic [3:0] VER_IPV4 = 4'h4;
  localparam logic [3:0] VER_IPV6 = 4'h6;

  // Header geometry
  localparam int V4_MIN_END   = 8;   // fragment fields end at byte 7
  localparam int V6_FIXED_LEN = 40;
  localparam int EXT_MIN_LEN  = 8;

  // IPv6 next header codes
  localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
  localparam logic [7:0] NH_ROUTING    = 8'd43;
  localparam logic [7:0] NH_FRAGMENT   = 8'd44;
  localparam logic [7:0] NH_ESP        = 8'd50;
  localparam logic [7:0] NH_AUTH       = 8'd51;
  localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
  localparam logic [7:0] NH_MOBILITY   = 8'd135;
  localparam logic [7:0] NH_HIP        = 8'd139;
  localparam logic [7:0] NH_SHIM6      = 8'd140;
  localparam logic [7:0] NH_EXP_A      = 8'd253;
  localparam logic [7:0] NH_EXP_B      = 8'd254;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_V4   = 3'd1,
    PH_V6   = 3'd2,
    PH_OPT  = 3'd3,
    PH_FRAG = 3'd4,
    PH_AUTH = 3'd5,
    PH_SKIP = 3'd6
  } ihfp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } ihfp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  ip_version;
    logic [12:0] header_length;
    logic        fragment_found;
    logic [31:0] identification;
    logic [12:0] fragment_offset;
    logic        more_fragments;
  } ihfp_out_t;

  typedef struct packed {
    logic res_valid;  // this byte settles the packet's result
    logic busy;       // a packet is being walked
  } ihfp_core_sts_t;

endpackage

[design/ihfp_core.sv]
// ----------------------------------------------------------------------------
// ihfp_core
// Per-byte parse state and the combinational step that walks the header chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihfp_core
  import ihfp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  ihfp_in_t       item,
  output ihfp_core_sts_t sts,
  output ihfp_out_t      res
);

  localparam logic [POS_W-1:0] V4_POS_ID_HI  = POS_W'(4);
  localparam logic [POS_W-1:0] V4_POS_ID_LO  = POS_W'(5);
  localparam logic [POS_W-1:0] V4_POS_OFF_HI = POS_W'(6);
  localparam logic [POS_W-1:0] V4_POS_OFF_LO = POS_W'(7);
  localparam logic [POS_W-1:0] V6_POS_NH     = POS_W'(6);
  localparam logic [2:0]       REL_NH        = 3'd0;
  localparam logic [2:0]       REL_OFF_HI    = 3'd2;
  localparam logic [2:0]       REL_OFF_LO    = 3'd3;
  localparam logic [2:0]       REL_ID_FIRST  = 3'd4;
  localparam logic [2:0]       REL_LAST      = 3'd7;
  localparam logic [POS_W:0]   MAX_W         = (POS_W + 1)'(MAX_HEADER_BYTES);
  localparam logic [POS_W:0]   EXT_MIN_W     = (POS_W + 1)'(EXT_MIN_LEN);

  ihfp_phase_t      phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [3:0]       ver_r, ver_nxt;
  logic [31:0]      ident_r, ident_nxt;
  logic [12:0]      off_r, off_nxt;
  logic             more_r, more_nxt;
  logic             fseen_r, fseen_nxt;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W:0]   pos_inc_w;
  logic             hdr_last;
  logic [2:0]       rel;
  logic [5:0]       v4_len;
  logic [11:0]      opt_len;
  logic [10:0]      auth_len;
  logic [POS_W:0]   ext_end_w;
  logic [POS_W:0]   disp_end_w;
  logic             disp_en;
  logic             disp_ext;
  ihfp_phase_t      disp_phase;
  logic             emit_en;
  logic [1:0]       emit_status;
  logic [12:0]      emit_len;
  logic             ok;
  logic             fr;

  assign pos_inc    = pos_r + POS_W'(1);
  assign pos_inc_w  = {1'b0, pos_inc} + (POS_W + 1)'(1);
  assign hdr_last   = (pos_inc_w == {1'b0, end_r});
  // Offset within the current 8-byte extension header; only the low bits matter.
  assign rel        = 3'(pos_inc - end_r);
  assign v4_len     = {item.data_byte[3:0], 2'b00};
  assign opt_len    = {({1'b0, item.data_byte} + 9'd1), 3'b000};
  assign auth_len   = {({1'b0, item.data_byte} + 9'd2), 2'b00};
  assign ext_end_w  = {1'b0, pos_r}
                    + ((phase_r == PH_OPT) ? (POS_W + 1)'(opt_len) : (POS_W + 1)'(auth_len));
  assign disp_end_w = {1'b0, end_r} + EXT_MIN_W;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    end_nxt     = end_r;
    ver_nxt     = ver_r;
    ident_nxt   = ident_r;
    off_nxt     = off_r;
    more_nxt    = more_r;
    fseen_nxt   = fseen_r;
    emit_en     = 1'b0;
    emit_status = STATUS_COMPLETE;
    emit_len    = '0;
    disp_en     = 1'b0;
    disp_ext    = 1'b0;
    disp_phase  = PH_IDLE;

    if (item.first_byte) begin
      pos_nxt   = '0;
      pend_nxt  = '0;
      end_nxt   = '0;
      ver_nxt   = item.data_byte[7:4];
      ident_nxt = '0;
      off_nxt   = '0;
      more_nxt  = 1'b0;
      fseen_nxt = 1'b0;
      phase_nxt = PH_IDLE;
      if (ver_nxt == VER_IPV4) begin
        pend_nxt  = 8'(v4_len);
        end_nxt   = (v4_len < 6'(V4_MIN_END)) ? POS_W'(V4_MIN_END) : POS_W'(v4_len);
        fseen_nxt = 1'b1;
        phase_nxt = PH_V4;
      end else if (ver_nxt == VER_IPV6) begin
        end_nxt   = POS_W'(V6_FIXED_LEN);
        phase_nxt = PH_V6;
      end else begin
        emit_en     = 1'b1;
        emit_status = STATUS_UNSUPPORTED;
      end
    end else if (phase_r != PH_IDLE) begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_V4: begin
          if (pos_inc == V4_POS_ID_HI) begin
            ident_nxt = {16'h0000, item.data_byte, 8'h00};
          end else if (pos_inc == V4_POS_ID_LO) begin
            ident_nxt = {ident_r[31:8], item.data_byte};
          end else if (pos_inc == V4_POS_OFF_HI) begin
            more_nxt = item.data_byte[5];
            off_nxt  = {item.data_byte[4:0], 8'h00};
          end else if (pos_inc == V4_POS_OFF_LO) begin
            off_nxt = {off_r[12:8], item.data_byte};
          end
          if (hdr_last) begin
            emit_en  = 1'b1;
            emit_len = 13'(pend_r);
          end
        end
        PH_V6: begin
          if (pos_inc == V6_POS_NH) begin
            pend_nxt = item.data_byte;
          end
          disp_en = hdr_last;
        end
        PH_OPT, PH_AUTH: begin
          if (rel == REL_NH) begin
            pend_nxt = item.data_byte;
          end else if (ext_end_w > MAX_W) begin
            emit_en     = 1'b1;
            emit_status = STATUS_TOO_LONG;
          end else begin
            end_nxt   = ext_end_w[POS_W-1:0];
            phase_nxt = PH_SKIP;
          end
        end
        PH_FRAG: begin
          if (rel == REL_NH) begin
            pend_nxt = item.data_byte;
          end else if (!fseen_r && rel == REL_OFF_HI) begin
            off_nxt = {item.data_byte, 5'b00000};
          end else if (!fseen_r && rel == REL_OFF_LO) begin
            off_nxt  = {off_r[12:5], item.data_byte[7:3]};
            more_nxt = item.data_byte[0];
          end else if (!fseen_r && rel >= REL_ID_FIRST) begin
            ident_nxt = {ident_r[23:0], item.data_byte};
          end
          if (rel == REL_LAST) begin
            fseen_nxt = 1'b1;
            disp_en   = 1'b1;
          end
        end
        PH_SKIP: begin
          disp_en = hdr_last;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Start the next header at end_r, or end the walk with a result.
    if (disp_en) begin
      case (pend_nxt)
        NH_HOP_BY_HOP, NH_DEST_OPTS, NH_ROUTING: begin
          disp_ext   = 1'b1;
          disp_phase = PH_OPT;
        end
        NH_FRAGMENT: begin
          disp_ext   = 1'b1;
          disp_phase = PH_FRAG;
        end
        NH_AUTH: begin
          disp_ext   = 1'b1;
          disp_phase = PH_AUTH;
        end
        NH_ESP, NH_MOBILITY, NH_HIP, NH_SHIM6, NH_EXP_A, NH_EXP_B: begin
          emit_en     = 1'b1;
          emit_status = STATUS_UNSUPPORTED;
        end
        default: begin
          emit_en  = 1'b1;
          emit_len = end_r[12:0];
        end
      endcase
      if (disp_ext) begin
        if (disp_end_w > MAX_W) begin
          emit_en     = 1'b1;
          emit_status = STATUS_TOO_LONG;
        end else begin
          end_nxt   = disp_end_w[POS_W-1:0];
          phase_nxt = disp_phase;
        end
      end
    end

    if (emit_en) begin
      phase_nxt = PH_IDLE;
    end
    if (!emit_en && item.last_byte && phase_nxt != PH_IDLE) begin
      emit_en     = 1'b1;
      emit_status = STATUS_TRUNCATED;
    end
    if (item.last_byte) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign ok = (emit_status == STATUS_COMPLETE);
  assign fr = ok && fseen_nxt;

  always_comb begin
    res.status          = emit_status;
    res.ip_version      = ver_nxt;
    res.header_length   = ok ? emit_len : 13'd0;
    res.fragment_found  = fr;
    res.identification  = fr ? ident_nxt : 32'd0;
    res.fragment_offset = fr ? off_nxt : 13'd0;
    res.more_fragments  = fr && more_nxt;
  end

  assign sts.res_valid = emit_en;
  assign sts.busy      = (phase_r != PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      pend_r  <= '0;
      end_r   <= '0;
      ver_r   <= '0;
      ident_r <= '0;
      off_r   <= '0;
      more_r  <= 1'b0;
      fseen_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      end_r   <= end_nxt;
      ver_r   <= ver_nxt;
      ident_r <= ident_nxt;
      off_r   <= off_nxt;
      more_r  <= more_nxt;
      fseen_r <= fseen_nxt;
    end
  end

endmodule

[design/ip_header_fragment_parser.sv]
// ----------------------------------------------------------------------------
// ip_header_fragment_parser
// Byte-stream IP header length and fragment field extractor.
// ----------------------------------------------------------------------------
// Feed an IP packet one byte per transaction, first_byte on the version byte
// and last_byte on the final one. Each packet yields exactly one result: the
// header length (IPv4 IHL, or the 40-byte IPv6 header plus its walked
// extension chain) with the fragment fields, or an unsupported, truncated or
// too-long status; bytes after the result are ignored until the next
// first_byte. The block takes one byte every cycle while the result side keeps
// up. A result reaches out_* by way of the input register and the result
// register: the byte sits in the input register, the parse step between it and
// the result register is combinational, and the result register loads when
// the held byte advances. While a result waits unaccepted, the held byte
// does not advance and the input stalls once the input register is full.
`timescale 1ns / 1ps

`include "ip_header_fragment_parser_macros.svh"

module ip_header_fragment_parser
  import ihfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ihfp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ihfp_out_t out_data
);

  logic           in_valid_r;
  ihfp_in_t       in_data_r;
  logic           out_valid_r;
  ihfp_out_t      out_data_r;
  logic           adv;
  ihfp_core_sts_t core_sts;
  ihfp_out_t      core_res;

  // Advance the held byte whenever the result register can take its result.
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  ihfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (in_data_r),
    .sts     (core_sts),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && core_sts.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && core_sts.res_valid) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IHFP_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_ready, "input stalled with empty result register")
  `IHFP_ASSERT_SAME(a_fail_no_length, out_valid_r && out_data_r.status != STATUS_COMPLETE, out_data_r.header_length == 13'd0 && !out_data_r.fragment_found, "failed result carries length or fragment data")
  `IHFP_ASSERT_SAME(a_v4_has_frag, out_valid_r && out_data_r.status == STATUS_COMPLETE && out_data_r.ip_version == VER_IPV4, out_data_r.fragment_found, "complete IPv4 result without fragment fields")
  `IHFP_ASSERT_NEXT(a_idle_after_result, adv && core_sts.res_valid, !core_sts.busy, "parser still busy after reporting")

endmodule
